>>> src/pwd_pkg.sv
// shared types and codes for the protobuf wire field decoder
package pwd_pkg;

  localparam int VARINT_MAX_BYTES_DEF = 10;

  typedef enum logic [2:0] {
    PH_TAG    = 3'd0,
    PH_VARINT = 3'd1,
    PH_FIXED  = 3'd2,
    PH_LENHDR = 3'd3,
    PH_BODY   = 3'd4,
    PH_DROP   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    TK_VARINT  = 3'd0,
    TK_FIXED32 = 3'd1,
    TK_FIXED64 = 3'd2,
    TK_LENHDR  = 3'd3,
    TK_PAYLOAD = 3'd4,
    TK_BARETAG = 3'd5,
    TK_ERROR   = 3'd6
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TRUNCATED = 2'd1,
    ERR_OVERLONG  = 2'd2
  } err_t;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LENDELIM = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  typedef struct packed {
    phase_t      phase;
    logic [63:0] acc;
    logic [3:0]  vcount;
    logic [31:0] fnum;
    logic [2:0]  wtype;
    logic [2:0]  fcount;
    logic [63:0] left;
  } pwd_state_t;

  localparam pwd_state_t STATE_RESET = '{
    phase: PH_TAG, acc: 64'd0, vcount: 4'd0, fnum: 32'd0,
    wtype: 3'd0, fcount: 3'd0, left: 64'd0
  };

  typedef struct packed {
    token_kind_t kind;
    logic [31:0] fnum;
    logic [2:0]  wtype;
    logic [63:0] value;
    logic [7:0]  pbyte;
    logic        plast;
    logic        msg_end;
    err_t        err;
  } pwd_token_t;

endpackage

>>> src/protobuf_wire_field_decoder.sv
// Streaming protobuf wire-format decoder, one message byte per cycle. Each
// accepted byte updates the parser state and gives at most one token, which
// sits in a single output register in the cycle after the byte; a byte is
// taken in every cycle unless that register holds a token that is stalled,
// so the rate is one byte per cycle while the output is not stalled. Tags
// give field number and wire type; varints (at most VARINT_MAX_BYTES bytes),
// fixed32, fixed64, length headers and body bytes give tokens of their own.
// An over-long varint or a message that ends mid-field gives an error token,
// and bytes are then dropped up to the end of the message.
module protobuf_wire_field_decoder #(
  parameter int VARINT_MAX_BYTES = pwd_pkg::VARINT_MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [2:0]  token_kind,
  output logic [31:0] field_number,
  output logic [2:0]  wire_type,
  output logic [63:0] field_value,
  output logic [7:0]  payload_byte,
  output logic        payload_last,
  output logic        message_end,
  output logic [1:0]  error_code
);
  import pwd_pkg::*;

  pwd_state_t state;
  pwd_state_t state_next;
  pwd_token_t step_tok;
  pwd_token_t held_tok;
  logic       step_valid;
  logic       accept;

  assign accept = data_valid && !data_stall;

  pwd_step #(
    .VARINT_MAX_BYTES(VARINT_MAX_BYTES)
  ) u_step (
    .cur       (state),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .nxt       (state_next),
    .tok_valid (step_valid),
    .tok       (step_tok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  pwd_outreg u_outreg (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && step_valid),
    .load_tok     (step_tok),
    .token_stall  (token_stall),
    .token_valid  (token_valid),
    .held_tok     (held_tok),
    .full_stalled (data_stall)
  );

  assign token_kind   = held_tok.kind;
  assign field_number = held_tok.fnum;
  assign wire_type    = held_tok.wtype;
  assign field_value  = held_tok.value;
  assign payload_byte = held_tok.pbyte;
  assign payload_last = held_tok.plast;
  assign message_end  = held_tok.msg_end;
  assign error_code   = held_tok.err;

  // every message end leaves the parser back at a fresh tag
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> state == STATE_RESET)
    else $error("parser state not cleared after message end");

  a_vcount_bound: assert property (@(posedge clk) disable iff (rst)
    state.vcount < 4'(VARINT_MAX_BYTES))
    else $error("varint byte count past limit");

  a_err_match: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> ((token_kind == TK_ERROR) == (error_code != ERR_NONE)))
    else $error("error code and token kind disagree");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_kind == TK_ERROR |->
      field_number == 32'd0 && wire_type == 3'd0 && field_value == 64'd0)
    else $error("error token carries field data");

  a_drop_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && state.phase == PH_DROP |=> !token_valid || $stable(held_tok))
    else $error("token given while dropping bytes");

endmodule

>>> src/pwd_step.sv
// per-byte parse step: next parser state and the token this byte gives
module pwd_step #(
  parameter int VARINT_MAX_BYTES = pwd_pkg::VARINT_MAX_BYTES_DEF
) (
  input  pwd_pkg::pwd_state_t cur,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output pwd_pkg::pwd_state_t nxt,
  output logic                tok_valid,
  output pwd_pkg::pwd_token_t tok
);
  import pwd_pkg::*;

  localparam logic [3:0] MaxBytes = 4'(VARINT_MAX_BYTES);

  logic [6:0]  vshift;
  logic [63:0] vacc;
  logic [3:0]  vcnt_inc;
  logic        vdone;
  logic        vlong;
  logic        need8;
  logic [63:0] facc;
  logic [63:0] left0;
  logic [63:0] lnext;
  logic        fin;
  logic        do_fail;
  err_t        fail_code;

  // 7 bits per varint byte; anything landing past bit 63 falls off
  assign vshift   = 7'({3'd0, cur.vcount} * 7'd7);
  assign vacc     = cur.acc | ({57'd0, data_byte[6:0]} << vshift);
  assign vcnt_inc = cur.vcount + 4'd1;
  assign vdone    = !data_byte[7];
  assign vlong    = data_byte[7] && (vcnt_inc >= MaxBytes);

  assign need8 = (cur.wtype == WT_FIXED64);
  assign facc  = cur.acc | ({56'd0, data_byte} << {cur.fcount, 3'b000});

  assign left0 = (cur.left == 64'd0) ? 64'd1 : cur.left;
  assign lnext = left0 - 64'd1;
  assign fin   = (lnext == 64'd0);

  always_comb begin
    nxt       = cur;
    tok_valid = 1'b0;
    tok       = '0;
    do_fail   = 1'b0;
    fail_code = ERR_NONE;
    tok.msg_end = last_byte;

    case (cur.phase)
      PH_DROP: begin
      end
      PH_VARINT, PH_LENHDR: begin
        if (vlong) begin
          do_fail   = 1'b1;
          fail_code = ERR_OVERLONG;
        end else if (!vdone) begin
          nxt.acc    = vacc;
          nxt.vcount = vcnt_inc;
          if (last_byte) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNCATED;
          end
        end else begin
          nxt.acc    = 64'd0;
          nxt.vcount = 4'd0;
          tok.fnum   = cur.fnum;
          tok.wtype  = cur.wtype;
          tok.value  = vacc;
          if (cur.phase == PH_VARINT) begin
            tok_valid = 1'b1;
            tok.kind  = TK_VARINT;
            nxt.phase = PH_TAG;
          end else if (vacc != 64'd0 && last_byte) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNCATED;
          end else begin
            tok_valid = 1'b1;
            tok.kind  = TK_LENHDR;
            nxt.left  = vacc;
            nxt.phase = (vacc == 64'd0) ? PH_TAG : PH_BODY;
          end
        end
      end
      PH_FIXED: begin
        if (need8 ? (cur.fcount != 3'd7) : (cur.fcount < 3'd3)) begin
          nxt.acc    = facc;
          nxt.fcount = cur.fcount + 3'd1;
          if (last_byte) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNCATED;
          end
        end else begin
          tok_valid  = 1'b1;
          tok.kind   = need8 ? TK_FIXED64 : TK_FIXED32;
          tok.fnum   = cur.fnum;
          tok.wtype  = cur.wtype;
          tok.value  = facc;
          nxt.acc    = 64'd0;
          nxt.fcount = 3'd0;
          nxt.phase  = PH_TAG;
        end
      end
      PH_BODY: begin
        if (!fin && last_byte) begin
          do_fail   = 1'b1;
          fail_code = ERR_TRUNCATED;
        end else begin
          tok_valid = 1'b1;
          tok.kind  = TK_PAYLOAD;
          tok.fnum  = cur.fnum;
          tok.wtype = cur.wtype;
          tok.pbyte = data_byte;
          tok.plast = fin;
          nxt.left  = lnext;
          if (fin) begin
            nxt.phase = PH_TAG;
          end
        end
      end
      default: begin
        // tag phase, also recovers from any unused phase code
        nxt.phase = PH_TAG;
        if (vlong) begin
          do_fail   = 1'b1;
          fail_code = ERR_OVERLONG;
        end else if (!vdone) begin
          nxt.acc    = vacc;
          nxt.vcount = vcnt_inc;
          if (last_byte) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNCATED;
          end
        end else begin
          nxt.fnum   = vacc[34:3];
          nxt.wtype  = vacc[2:0];
          nxt.acc    = 64'd0;
          nxt.vcount = 4'd0;
          nxt.fcount = 3'd0;
          case (vacc[2:0])
            WT_VARINT:   nxt.phase = PH_VARINT;
            WT_FIXED64:  nxt.phase = PH_FIXED;
            WT_LENDELIM: nxt.phase = PH_LENHDR;
            WT_FIXED32:  nxt.phase = PH_FIXED;
            default: begin
              tok_valid = 1'b1;
              tok.kind  = TK_BARETAG;
              tok.fnum  = vacc[34:3];
              tok.wtype = vacc[2:0];
            end
          endcase
          if (!tok_valid && last_byte) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNCATED;
          end
        end
      end
    endcase

    if (last_byte) begin
      nxt = STATE_RESET;
    end

    if (do_fail) begin
      tok_valid   = 1'b1;
      tok         = '0;
      tok.kind    = TK_ERROR;
      tok.err     = fail_code;
      tok.msg_end = last_byte;
      nxt         = STATE_RESET;
      // without a message end, drop bytes until it comes
      if (!last_byte) begin
        nxt.phase = PH_DROP;
      end
    end
  end

endmodule

>>> src/pwd_outreg.sv
// token output register, lets a new byte in while the held token drains
module pwd_outreg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  pwd_pkg::pwd_token_t load_tok,
  input  logic                token_stall,
  output logic                token_valid,
  output pwd_pkg::pwd_token_t held_tok,
  output logic                full_stalled
);
  import pwd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (load) begin
      token_valid <= 1'b1;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_tok <= load_tok;
    end
  end

  assign full_stalled = token_valid && token_stall;

endmodule
